### hdl/lpi_pkg.sv
// lpi_pkg: shared constants, relation codes and sideband type of the line pair
// intersection unit
// depends on nothing; used by lpi_front, line_pair_intersection_unit and lpi_checker
package lpi_pkg;

    localparam int IN_W            = 12;
    localparam int OUT_W           = 54;
    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [1:0] REL_PARALLEL = 2'd0;
    localparam logic [1:0] REL_SAME     = 2'd1;
    localparam logic [1:0] REL_CROSS    = 2'd2;

    // saturation limits of the output range, held at 64 bits
    localparam logic [63:0] OUT_MAX_MAG = 64'd9007199254740991;
    localparam logic [63:0] OUT_MIN_MAG = 64'd9007199254740992;

    typedef struct packed {
        logic [1:0] relation;
        logic       neg;
    } lpi_side_t;

endpackage

### hdl/lpi_front.sv
// lpi_front: four register stages forming differences, cross products,
// numerators, the divisor and their magnitudes
// depends on lpi_pkg
module lpi_front #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF,
    parameter int DW         = COORD_BITS + 1,
    parameter int CW         = 2 * DW + 1,
    parameter int PW         = CW + COORD_BITS + 1,
    parameter int NW         = PW + FRAC_BITS,
    parameter int DEN_W      = CW + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [lpi_pkg::IN_W-1:0]  a_x0,
    input  logic [lpi_pkg::IN_W-1:0]  a_y0,
    input  logic [lpi_pkg::IN_W-1:0]  a_x1,
    input  logic [lpi_pkg::IN_W-1:0]  a_y1,
    input  logic [lpi_pkg::IN_W-1:0]  b_x0,
    input  logic [lpi_pkg::IN_W-1:0]  b_y0,
    input  logic [lpi_pkg::IN_W-1:0]  b_x1,
    input  logic [lpi_pkg::IN_W-1:0]  b_y1,
    output logic                      f_valid,
    output logic [NW-1:0]             num_x_mag,
    output logic [NW-1:0]             num_y_mag,
    output logic [DEN_W-1:0]          den_mag,
    output lpi_pkg::lpi_side_t        side_x,
    output lpi_pkg::lpi_side_t        side_y
);

    // coordinates cut to COORD_BITS, sign extended by one for differences
    logic signed [COORD_BITS-1:0] ax0_c, ay0_c, ax1_c, ay1_c;
    logic signed [COORD_BITS-1:0] bx0_c, by0_c, bx1_c, by1_c;
    logic signed [DW-1:0] dax_next, day_next, dbx_next, dby_next;
    logic signed [DW-1:0] e1x_next, e1y_next, e0x_next, e0y_next;

    assign ax0_c = a_x0[COORD_BITS-1:0];
    assign ay0_c = a_y0[COORD_BITS-1:0];
    assign ax1_c = a_x1[COORD_BITS-1:0];
    assign ay1_c = a_y1[COORD_BITS-1:0];
    assign bx0_c = b_x0[COORD_BITS-1:0];
    assign by0_c = b_y0[COORD_BITS-1:0];
    assign bx1_c = b_x1[COORD_BITS-1:0];
    assign by1_c = b_y1[COORD_BITS-1:0];

    assign dax_next = DW'(ax1_c) - DW'(ax0_c);
    assign day_next = DW'(ay1_c) - DW'(ay0_c);
    assign dbx_next = DW'(bx1_c) - DW'(bx0_c);
    assign dby_next = DW'(by1_c) - DW'(by0_c);
    assign e1x_next = DW'(bx1_c) - DW'(ax0_c);
    assign e1y_next = DW'(by1_c) - DW'(ay0_c);
    assign e0x_next = DW'(bx0_c) - DW'(ax0_c);
    assign e0y_next = DW'(by0_c) - DW'(ay0_c);

    // stage 1: differences
    logic v1_reg;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [DW-1:0] e1x_reg, e1y_reg, e0x_reg, e0y_reg;
    logic signed [COORD_BITS-1:0] bx0_1_reg, bx1_1_reg, by0_1_reg, by1_1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg   <= dax_next;
            day_reg   <= day_next;
            dbx_reg   <= dbx_next;
            dby_reg   <= dby_next;
            e1x_reg   <= e1x_next;
            e1y_reg   <= e1y_next;
            e0x_reg   <= e0x_next;
            e0y_reg   <= e0y_next;
            bx0_1_reg <= bx0_c;
            bx1_1_reg <= bx1_c;
            by0_1_reg <= by0_c;
            by1_1_reg <= by1_c;
        end
    end

    // stage 2: cross products
    logic signed [CW-1:0] d_next, p_next, q_next, s_next;
    assign d_next = dax_reg * dby_reg - day_reg * dbx_reg;
    assign p_next = e1x_reg * day_reg - e1y_reg * dax_reg;
    assign q_next = e0x_reg * day_reg - e0y_reg * dax_reg;
    assign s_next = e0x_reg * dby_reg - e0y_reg * dbx_reg;

    logic v2_reg;
    logic signed [CW-1:0] d_reg, p_reg, q_reg, s_reg;
    logic signed [COORD_BITS-1:0] bx0_2_reg, bx1_2_reg, by0_2_reg, by1_2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            s_reg     <= s_next;
            bx0_2_reg <= bx0_1_reg;
            bx1_2_reg <= bx1_1_reg;
            by0_2_reg <= by0_1_reg;
            by1_2_reg <= by1_1_reg;
        end
    end

    // stage 3: numerators, divisor and relation
    logic signed [PW-1:0]    nx_next, ny_next;
    logic signed [DEN_W-1:0] den_next;
    logic [1:0]              rel_next;

    assign nx_next  = p_reg * bx0_2_reg - q_reg * bx1_2_reg;
    assign ny_next  = p_reg * by0_2_reg - q_reg * by1_2_reg;
    assign den_next = DEN_W'(p_reg) - DEN_W'(q_reg);

    always_comb
    begin
        if (d_reg != '0)
            rel_next = lpi_pkg::REL_CROSS;
        else if (s_reg == '0)
            rel_next = lpi_pkg::REL_SAME;
        else
            rel_next = lpi_pkg::REL_PARALLEL;
    end

    logic v3_reg;
    logic signed [PW-1:0]    nx_reg, ny_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic [1:0]              rel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            den_reg <= den_next;
            rel_reg <= rel_next;
        end
    end

    // stage 4: magnitudes and quotient signs
    logic [PW-1:0]    nx_abs, ny_abs;
    logic [DEN_W-1:0] den_abs;

    assign nx_abs  = nx_reg[PW-1] ? PW'(-nx_reg) : PW'(nx_reg);
    assign ny_abs  = ny_reg[PW-1] ? PW'(-ny_reg) : PW'(ny_reg);
    assign den_abs = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);

    logic v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_mag       <= NW'(nx_abs) << FRAC_BITS;
            num_y_mag       <= NW'(ny_abs) << FRAC_BITS;
            den_mag         <= den_abs;
            side_x.relation <= rel_reg;
            side_x.neg      <= nx_reg[PW-1] ^ den_reg[DEN_W-1];
            side_y.relation <= rel_reg;
            side_y.neg      <= ny_reg[PW-1] ^ den_reg[DEN_W-1];
        end
    end

    assign f_valid = v4_reg;

endmodule

### hdl/lpi_divider.sv
// lpi_divider: pipelined restoring divider, one quotient bit per stage,
// carrying a sideband alongside
// depends on nothing beyond its parameters
module lpi_divider #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 28,
    parameter int SB_W  = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             d_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  side,
    output logic             q_valid,
    output logic [NUM_W-1:0] quot,
    output logic [SB_W-1:0]  q_side
);

    logic [DEN_W-1:0] rem_reg  [NUM_W];
    logic [NUM_W-1:0] num_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];
    logic [SB_W-1:0]  side_reg [NUM_W];
    logic             vld_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [SB_W-1:0]  side_in;
        logic             vld_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] num_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign num_in  = num;
            assign den_in  = den;
            assign side_in = side;
            assign vld_in  = d_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial    = {rem_in, num_in[NUM_W-1]};
        assign ge       = trial >= {1'b0, den_in};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign num_next = {num_in[NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign q_valid = vld_reg[NUM_W-1];
    assign quot    = num_reg[NUM_W-1];
    assign q_side  = side_reg[NUM_W-1];

endmodule

### hdl/line_pair_intersection_unit.sv
// line_pair_intersection_unit: top level of the line pair intersection block
// depends on lpi_pkg, lpi_front and lpi_divider
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, a_x0 .. b_y1          | item in
//  out     | out_valid, out_ready, relation, cross_x/y | item out
//
// one item enters per cycle while the output is not held; the pipeline holds
// four front stages, one divider stage per quotient bit and one output
// register. the pipelined restoring divider sets the depth.
// reset clears every valid bit; payload registers are not reset.
// a held output stalls the whole pipeline in place; nothing is lost or repeated.
module line_pair_intersection_unit #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lpi_pkg::IN_W-1:0]          a_x0,
    input  logic [lpi_pkg::IN_W-1:0]          a_y0,
    input  logic [lpi_pkg::IN_W-1:0]          a_x1,
    input  logic [lpi_pkg::IN_W-1:0]          a_y1,
    input  logic [lpi_pkg::IN_W-1:0]          b_x0,
    input  logic [lpi_pkg::IN_W-1:0]          b_y0,
    input  logic [lpi_pkg::IN_W-1:0]          b_x1,
    input  logic [lpi_pkg::IN_W-1:0]          b_y1,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        relation,
    output logic signed [lpi_pkg::OUT_W-1:0]  cross_x,
    output logic signed [lpi_pkg::OUT_W-1:0]  cross_y
);

    // widths follow from the coordinate and fraction widths
    localparam int DW    = COORD_BITS + 1;            // coordinate differences
    localparam int CW    = 2 * DW + 1;                // cross products
    localparam int PW    = CW + COORD_BITS + 1;       // numerators before scaling
    localparam int NW    = PW + FRAC_BITS;            // scaled numerator magnitude
    localparam int DEN_W = CW + 1;                    // divisor p - q
    localparam int SB_W  = $bits(lpi_pkg::lpi_side_t);

    // global advance: the pipeline moves whenever the output slot can take an item
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    logic                 f_valid;
    logic [NW-1:0]        num_x_mag, num_y_mag;
    logic [DEN_W-1:0]     den_mag;
    lpi_pkg::lpi_side_t   side_x, side_y;

    lpi_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .DW         (DW),
        .CW         (CW),
        .PW         (PW),
        .NW         (NW),
        .DEN_W      (DEN_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a_x0      (a_x0),
        .a_y0      (a_y0),
        .a_x1      (a_x1),
        .a_y1      (a_y1),
        .b_x0      (b_x0),
        .b_y0      (b_y0),
        .b_x1      (b_x1),
        .b_y1      (b_y1),
        .f_valid   (f_valid),
        .num_x_mag (num_x_mag),
        .num_y_mag (num_y_mag),
        .den_mag   (den_mag),
        .side_x    (side_x),
        .side_y    (side_y)
    );

    // one divider per coordinate; both valids run in lockstep
    logic                qx_valid, qy_valid;
    logic [NW-1:0]       quot_x, quot_y;
    logic [SB_W-1:0]     qside_x_bits, qside_y_bits;
    lpi_pkg::lpi_side_t  qside_x, qside_y;

    lpi_divider #(
        .NUM_W (NW),
        .DEN_W (DEN_W),
        .SB_W  (SB_W)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .d_valid (f_valid),
        .num     (num_x_mag),
        .den     (den_mag),
        .side    (side_x),
        .q_valid (qx_valid),
        .quot    (quot_x),
        .q_side  (qside_x_bits)
    );

    lpi_divider #(
        .NUM_W (NW),
        .DEN_W (DEN_W),
        .SB_W  (SB_W)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .d_valid (f_valid),
        .num     (num_y_mag),
        .den     (den_mag),
        .side    (side_y),
        .q_valid (qy_valid),
        .quot    (quot_y),
        .q_side  (qside_y_bits)
    );

    assign qside_x = lpi_pkg::lpi_side_t'(qside_x_bits);
    assign qside_y = lpi_pkg::lpi_side_t'(qside_y_bits);

    // sign, saturation to the output range, zero when there is no crossing
    logic [63:0]                     qx64, qy64;
    logic [lpi_pkg::OUT_W-1:0]       cx_next, cy_next;

    assign qx64 = 64'(quot_x);
    assign qy64 = 64'(quot_y);

    always_comb
    begin
        if (qside_x.relation != lpi_pkg::REL_CROSS)
            cx_next = '0;
        else if (!qside_x.neg && qx64 > lpi_pkg::OUT_MAX_MAG)
            cx_next = lpi_pkg::OUT_MAX_MAG[lpi_pkg::OUT_W-1:0];
        else if (qside_x.neg && qx64 > lpi_pkg::OUT_MIN_MAG)
            cx_next = lpi_pkg::OUT_MIN_MAG[lpi_pkg::OUT_W-1:0];
        else if (qside_x.neg)
            cx_next = lpi_pkg::OUT_W'(-qx64);
        else
            cx_next = qx64[lpi_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        if (qside_y.relation != lpi_pkg::REL_CROSS)
            cy_next = '0;
        else if (!qside_y.neg && qy64 > lpi_pkg::OUT_MAX_MAG)
            cy_next = lpi_pkg::OUT_MAX_MAG[lpi_pkg::OUT_W-1:0];
        else if (qside_y.neg && qy64 > lpi_pkg::OUT_MIN_MAG)
            cy_next = lpi_pkg::OUT_MIN_MAG[lpi_pkg::OUT_W-1:0];
        else if (qside_y.neg)
            cy_next = lpi_pkg::OUT_W'(-qy64);
        else
            cy_next = qy64[lpi_pkg::OUT_W-1:0];
    end

    // output register
    logic [1:0]                relation_reg;
    logic [lpi_pkg::OUT_W-1:0] cross_x_reg, cross_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= qx_valid && qy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            relation_reg <= qside_x.relation;
            cross_x_reg  <= cx_next;
            cross_y_reg  <= cy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign relation  = relation_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

endmodule

### hdl/lpi_checker.sv
// lpi_checker: port-level assertions for line_pair_intersection_unit, and the
// bind that attaches them; depends on lpi_pkg
module lpi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [1:0]                        relation,
    input logic signed [lpi_pkg::OUT_W-1:0]  cross_x,
    input logic signed [lpi_pkg::OUT_W-1:0]  cross_y
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relation)
            && $stable(cross_x) && $stable(cross_y))
        else $error("held result changed");

    // no crossing means a zero point
    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relation != lpi_pkg::REL_CROSS |-> cross_x == '0 && cross_y == '0)
        else $error("point not zero without a crossing");

    // relation is one of the three codes
    a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> relation == lpi_pkg::REL_PARALLEL || relation == lpi_pkg::REL_SAME
            || relation == lpi_pkg::REL_CROSS)
        else $error("bad relation code");

    // input side stalls only behind a held result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input stalled without a held result");

endmodule

bind line_pair_intersection_unit lpi_checker u_lpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .relation  (relation),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
);

### dv/line_pair_intersection_unit_test.sv
// line_pair_intersection_unit_test: self-checking bench for the line pair intersection unit
// depends on lpi_pkg and line_pair_intersection_unit; predicts relation and crossing point
`timescale 1ns / 100ps

module line_pair_intersection_unit_test;

    typedef struct {
        logic [lpi_pkg::IN_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } line_pair_t;

    typedef struct {
        logic [1:0]                 rel;
        logic [lpi_pkg::OUT_W-1:0]  px;
        logic [lpi_pkg::OUT_W-1:0]  py;
    } crossing_t;

    // exact integer predictor of the crossing, with a queue of pending crossings
    class crossing_board;
        crossing_t pending[$];

        function longint coord(logic [lpi_pkg::IN_W-1:0] v);
            logic signed [lpi_pkg::COORD_BITS_DEF-1:0] c;
            c = v[lpi_pkg::COORD_BITS_DEF-1:0];
            return longint'(c);
        endfunction

        function longint cross2(longint ux, longint uy, longint vx, longint vy);
            return ux * vy - uy * vx;
        endfunction

        // fixed point quotient, truncated toward zero, saturated to the output range
        function logic [lpi_pkg::OUT_W-1:0] fix_quot(longint p, longint q, longint c0,
                                                     longint c1);
            longint num;
            longint r;
            num = (p * c0 - q * c1) * (longint'(1) <<< lpi_pkg::FRAC_BITS_DEF);
            r = num / (p - q);
            if (r > longint'(lpi_pkg::OUT_MAX_MAG))
                r = longint'(lpi_pkg::OUT_MAX_MAG);
            if (r < -longint'(lpi_pkg::OUT_MIN_MAG))
                r = -longint'(lpi_pkg::OUT_MIN_MAG);
            return r[lpi_pkg::OUT_W-1:0];
        endfunction

        function void note(line_pair_t lp);
            longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
            longint dax, day, dbx, dby, d, p, q;
            crossing_t e;
            ax0 = coord(lp.ax0); ay0 = coord(lp.ay0);
            ax1 = coord(lp.ax1); ay1 = coord(lp.ay1);
            bx0 = coord(lp.bx0); by0 = coord(lp.by0);
            bx1 = coord(lp.bx1); by1 = coord(lp.by1);
            dax = ax1 - ax0; day = ay1 - ay0;
            dbx = bx1 - bx0; dby = by1 - by0;
            d = cross2(dax, day, dbx, dby);
            if (d != 0)
            begin
                p = cross2(bx1 - ax0, by1 - ay0, dax, day);
                q = cross2(bx0 - ax0, by0 - ay0, dax, day);
                e.rel = lpi_pkg::REL_CROSS;
                e.px = fix_quot(p, q, bx0, bx1);
                e.py = fix_quot(p, q, by0, by1);
            end
            else
            begin
                e.rel = (cross2(ax0 - bx0, ay0 - by0, dbx, dby) == 0) ?
                        lpi_pkg::REL_SAME : lpi_pkg::REL_PARALLEL;
                e.px = '0;
                e.py = '0;
            end
            pending.push_back(e);
        endfunction

        // returns an empty string when the item matches
        function string check(logic [1:0] rel, logic [lpi_pkg::OUT_W-1:0] px,
                              logic [lpi_pkg::OUT_W-1:0] py);
            crossing_t e;
            if (pending.size() == 0)
                return "result item with nothing expected";
            e = pending.pop_front();
            if (rel !== e.rel)
                return $sformatf("relation %0d, expected %0d", rel, e.rel);
            if (px !== e.px)
                return $sformatf("cross_x %0d, expected %0d", $signed(px), $signed(e.px));
            if (py !== e.py)
                return $sformatf("cross_y %0d, expected %0d", $signed(py), $signed(e.py));
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [lpi_pkg::IN_W-1:0] a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1;
    logic out_valid;
    logic out_ready;
    logic [1:0] relation;
    logic signed [lpi_pkg::OUT_W-1:0] cross_x;
    logic signed [lpi_pkg::OUT_W-1:0] cross_y;

    crossing_board board;
    int  mismatches;
    int  pairs_taken;
    int  idle_cycles;

    line_pair_intersection_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x0      (a_x0),
        .a_y0      (a_y0),
        .a_x1      (a_x1),
        .a_y1      (a_y1),
        .b_x0      (b_x0),
        .b_y0      (b_y0),
        .b_x1      (b_x1),
        .b_y1      (b_y1),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .relation  (relation),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    // input side: note every item taken at a rising edge
    always @(posedge clk)
    begin
        line_pair_t lp;
        if (rst_n && in_valid && in_ready)
        begin
            lp.ax0 = a_x0; lp.ay0 = a_y0; lp.ax1 = a_x1; lp.ay1 = a_y1;
            lp.bx0 = b_x0; lp.by0 = b_y0; lp.bx1 = b_x1; lp.by1 = b_y1;
            board.note(lp);
            pairs_taken++;
        end
    end

    // output side: check every item handed over
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = board.check(relation, cross_x, cross_y);
            if (msg != "")
                report(msg);
        end
    end

    // watchdog on cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= 5000)
        begin
            $display("line_pair_intersection_unit_test failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off once the pipe is busy
    initial
    begin
        int n;
        bit held;
        out_ready = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && pairs_taken >= 400)
            begin
                held = 1'b1;
                out_ready = 1'b0;
                repeat (250) @(negedge clk);
            end
            n = gap_len();
            if ($urandom_range(0, 3) == 0)
                n = 0;
            if (n > 0)
            begin
                out_ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // offer one pair and hold it until taken; called at a falling edge
    task automatic send(int x0, int y0, int x1, int y1, int u0, int v0, int u1, int v1);
        bit taken;
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        a_x0 = x0[lpi_pkg::IN_W-1:0]; a_y0 = y0[lpi_pkg::IN_W-1:0];
        a_x1 = x1[lpi_pkg::IN_W-1:0]; a_y1 = y1[lpi_pkg::IN_W-1:0];
        b_x0 = u0[lpi_pkg::IN_W-1:0]; b_y0 = v0[lpi_pkg::IN_W-1:0];
        b_x1 = u1[lpi_pkg::IN_W-1:0]; b_y1 = v1[lpi_pkg::IN_W-1:0];
        in_valid = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = in_valid && in_ready;
            @(negedge clk);
        end
    endtask

    function automatic int rnd_coord();
        return $urandom_range(0, 4095) - 2048;
    endfunction

    function automatic int small_val(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    // one random pair, weighted toward the shapes that hit each relation
    task automatic send_random();
        int kind, x0, y0, dx, dy, t0, t1, k, ox, oy;
        kind = $urandom_range(0, 99);
        x0 = small_val(1000); y0 = small_val(1000);
        dx = small_val(30); dy = small_val(30);
        t0 = small_val(30); t1 = small_val(30);
        if (kind < 40)
            send(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        else if (kind < 60)
            // both points of b on line a
            send(x0, y0, x0 + dx, y0 + dy,
                 x0 + t0 * dx, y0 + t0 * dy, x0 + t1 * dx, y0 + t1 * dy);
        else if (kind < 78)
        begin
            // b parallel to a, usually shifted off it
            ox = small_val(500); oy = small_val(500);
            k = small_val(20);
            send(x0, y0, x0 + dx, y0 + dy,
                 x0 + ox, y0 + oy, x0 + ox + k * dx, y0 + oy + k * dy);
        end
        else if (kind < 88)
        begin
            // nearly parallel, far-off crossing, often saturating
            ox = small_val(2000); oy = small_val(2000);
            send(-2048, -2048 + $urandom_range(0, 1), 2047, 2047,
                 ox, oy, ox + 4095, oy + 4095 + small_val(1));
        end
        else if (kind < 94)
            // degenerate line a or b
            send(x0, y0, x0, y0, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        else
            send(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), x0, y0, x0, y0);
    endtask

    initial
    begin
        board = new();
        mismatches = 0;
        pairs_taken = 0;
        idle_cycles = 0;
        in_valid = 1'b0;
        {a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1} = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, each relation, degenerate lines, saturation
        send(-2048, -2048, 2047, 2047, -2048, 2047, 2047, -2048);
        send(2047, 2047, -2048, -2048, 2047, -2048, -2048, 2047);
        send(0, 0, 1, 0, 0, 0, 0, 1);
        send(0, 0, 1, 1, 0, 1, 1, 0);
        send(0, 0, 1, 1, 2, 2, -5, -5);
        send(0, 0, 1, 1, 0, 1, 1, 2);
        send(-2048, 0, 2047, 0, -2048, 5, 2047, 5);
        send(3, 3, 3, 3, 1, 1, 7, 7);
        send(3, 3, 3, 3, 1, 2, 7, 7);
        send(1, 1, 9, 9, 4, 4, 4, 4);
        send(1, 1, 1, 1, 1, 1, 1, 1);
        send(1, 1, 1, 1, 2, 2, 2, 2);
        send(-2048, -2048, 2047, 2047, -2048, -2047, 2047, 2047);
        send(2047, -2048, -2048, 2047, 2047, -2047, -2048, 2047);
        send(-2048, -2048, 2047, 2047, 2047, -2048, -2048, 2047 - 1);
        send(0, 0, 3, 1, 1, 0, 0, 3);
        send(-1, -1, -1, -1, -1, -1, -1, -1);
        send(0, 0, 0, 0, 0, 0, 0, 0);
        send(-2048, 2047, -2048, -2048, 2047, 2047, 2047, -2048);
        send(-2048, 2047, -2048, -2048, -2048, 0, -2048, 1);

        repeat (1880)
            send_random();
        in_valid = 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        if (mismatches == 0)
            $display("line_pair_intersection_unit_test passed");
        else
            $display("line_pair_intersection_unit_test failed");
        $finish;
    end

endmodule
